FILE: rtl/bamau_pkg.sv
// Shared constants for the block average then moving average unit.
// Holds the default geometry and the fixed-point format of the result.
// No dependencies.
`default_nettype none

package bamau_pkg;

   localparam int BLOCK_LEN_DEF   = 16;
   localparam int NUM_BLOCKS_DEF  = 4;
   localparam int SAMPLE_BITS_DEF = 24;

   // The result is unsigned fixed point with this many fraction bits.
   localparam int FRAC_BITS = 6;
   localparam int MEAN_BITS = 30;

endpackage : bamau_pkg

`default_nettype wire

FILE: rtl/bamau_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the ring of block sums. No dependencies.
`default_nettype none

module bamau_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : bamau_ram

`default_nettype wire

FILE: rtl/block_average_then_moving_average_unit.sv
// Once warmed up, a result follows every BLOCK_LEN samples, in the cycle after the transfer
// of the block's last sample. One sample per cycle, but that sample waits while a result is stalled.
// The ring of block sums lives in bamau_ram; the slot to be replaced is read ahead of time.
// Reset clears the sample counter, accumulator, ring index, warm-up flag and window total.
// The ring itself is not cleared; its contents are only used after every slot has been written.
// Depends on bamau_pkg and bamau_ram.
`default_nettype none

module block_average_then_moving_average_unit
   import bamau_pkg::*;
#(
   parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
   parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [MEAN_BITS-1:0]   rsp_mean_scaled
);

   localparam int CNT_W   = $clog2(BLOCK_LEN);
   localparam int IDX_W   = $clog2(NUM_BLOCKS);
   localparam int LOG_WIN = CNT_W + IDX_W;
   localparam int ACC_W   = SAMPLE_BITS + CNT_W;
   localparam int WIN_W   = SAMPLE_BITS + LOG_WIN;
   localparam int EXT_W   = (WIN_W + FRAC_BITS > MEAN_BITS) ? WIN_W + FRAC_BITS : MEAN_BITS;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BLOCKS - 1);

   logic [CNT_W-1:0]     count_ff,  count_in;
   logic [ACC_W-1:0]     acc_ff,    acc_in;
   logic [IDX_W-1:0]     index_ff,  index_in;
   logic                 warm_ff,   warm_in;
   logic [WIN_W-1:0]     total_ff,  total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MEAN_BITS-1:0] mean_ff,   mean_in;

   logic             accept;
   logic             done;
   logic             emit;
   logic [ACC_W-1:0] block_sum;
   logic [ACC_W-1:0] old_sum;
   logic [EXT_W-1:0] mean_ext;

   // Only the sample that would produce a result has to wait for the output register.
   assign emit      = (count_ff == CNT_LAST) && (warm_ff || (index_ff == IDX_LAST));
   assign req_stall = rsp_valid_ff && rsp_stall && emit;
   assign accept    = req_valid && !req_stall;
   assign done      = accept && (count_ff == CNT_LAST);
   assign block_sum = acc_ff + ACC_W'(req_sample);

   // The read address follows the ring index, so the slot about to be replaced is
   // already on the read port; a block takes at least two transfers after the index moves.
   bamau_ram #(
      .WIDTH (ACC_W),
      .DEPTH (NUM_BLOCKS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (done),
      .wr_addr (index_ff),
      .wr_data (block_sum),
      .rd_addr (index_ff),
      .rd_data (old_sum)
   );

   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      index_in = index_ff;
      warm_in  = warm_ff;
      total_in = total_ff;
      if (accept) begin
         count_in = count_ff + CNT_W'(1);
         acc_in   = done ? '0 : block_sum;
      end
      if (done) begin
         index_in = index_ff + IDX_W'(1);
         warm_in  = warm_ff || (index_ff == IDX_LAST);
         total_in = total_ff + WIN_W'(block_sum) - (warm_ff ? WIN_W'(old_sum) : '0);
      end
   end

   assign mean_ext = (EXT_W'(total_in) << FRAC_BITS) >> LOG_WIN;
   assign mean_in  = mean_ext[MEAN_BITS-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         acc_ff       <= '0;
         index_ff     <= '0;
         warm_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         index_ff     <= index_in;
         warm_ff      <= warm_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && emit) begin
         mean_ff <= mean_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_scaled = mean_ff;

   a_rise_from_block : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done && emit))
      else $error("result appeared without a completed block");

   a_warm_before_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> warm_ff)
      else $error("result presented before the ring was filled");

   a_index_moves_on_block : assert property (@(posedge clock) disable iff (reset)
      !done |=> $stable(index_ff))
      else $error("ring index moved without a completed block");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(done && emit))
      else $error("pending result overwritten while stalled");

endmodule : block_average_then_moving_average_unit

`default_nettype wire
